// File: hw/rtl/ula_pkg.sv
// Shared constants and controller/datapath handshake types for the line assembler.
package ula_pkg;

    localparam int LINE_BUF_BYTES_DEF = 32;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SEND = 3'b100
    } ula_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;   // input beat accepted this cycle
        logic load_first;  // move first stored byte into the output register
        logic advance;     // output beat taken, move the next byte in
        logic in_load;     // read port addresses the prefetch index
        logic in_send;
    } ula_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic start_data;  // newline that ends a non-empty line
        logic start_empty; // newline that ends an empty line
        logic out_last;    // output register holds the final beat of the line
    } ula_stat_t;

endpackage

// File: hw/rtl/ula_ctrl.sv
// Controller state machine: input acceptance and line emission sequencing.
module ula_ctrl
    import ula_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  ula_stat_t stat,
    output ula_cmd_t  cmd
);

    ula_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (stat.start_data) begin
                        state_next = ST_LOAD;
                    end else if (stat.start_empty) begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_LOAD: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready && stat.out_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_SEND);
    assign cmd.take_byte  = s_ready && s_valid;
    assign cmd.load_first = (state_reg == ST_LOAD);
    assign cmd.advance    = m_valid && m_ready && !stat.out_last;
    assign cmd.in_load    = (state_reg == ST_LOAD);
    assign cmd.in_send    = (state_reg == ST_SEND);

endmodule

// File: hw/rtl/ula_dp.sv
// Datapath: line store, fill/discard tracking, read prefetch and output register.
module ula_dp
    import ula_pkg::*;
#(
    parameter int LINE_BUF_BYTES = LINE_BUF_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_rx_byte,
    input  ula_cmd_t   cmd,
    output ula_stat_t  stat,
    output logic [7:0] m_line_byte,
    output logic       m_empty_line,
    output logic       m_last_of_line
);

    localparam int AW = $clog2(LINE_BUF_BYTES);
    localparam logic [AW-1:0] CAP = AW'(LINE_BUF_BYTES - 1);

    logic [7:0] mem [2**AW];

    logic [AW-1:0] fill_reg;
    logic          discard_reg;
    logic          last_cr_reg;
    logic [AW-1:0] len_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    out_byte_reg;
    logic          out_empty_reg;
    logic          out_last_reg;

    logic          is_nl;
    logic [AW-1:0] line_len;
    logic [AW-1:0] rd_idx_inc;
    logic [AW-1:0] rd_addr;

    assign is_nl      = (s_rx_byte == CH_NL);
    // drop one trailing carriage return
    assign line_len   = fill_reg - AW'(last_cr_reg && (fill_reg != '0));
    assign rd_idx_inc = rd_idx_reg + AW'(1);

    assign stat.start_data  = is_nl && !discard_reg && (line_len != '0);
    assign stat.start_empty = is_nl && !discard_reg && (line_len == '0);
    assign stat.out_last    = out_last_reg;

    always_comb begin
        if (cmd.in_send && cmd.advance) begin
            rd_addr = rd_idx_inc;
        end else if (cmd.in_send || cmd.in_load) begin
            rd_addr = rd_idx_reg;
        end else begin
            rd_addr = '0;
        end
    end

    // line store: write while gathering, registered read
    always_ff @(posedge aclk) begin
        if (cmd.take_byte && !is_nl && !discard_reg && (fill_reg != CAP)) begin
            mem[fill_reg] <= s_rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            discard_reg <= 1'b0;
            last_cr_reg <= 1'b0;
        end else if (cmd.take_byte) begin
            if (is_nl) begin
                discard_reg <= 1'b0;
                if (!discard_reg) begin
                    fill_reg <= '0;
                end
            end else if (!discard_reg) begin
                if (fill_reg == CAP) begin
                    discard_reg <= 1'b1;
                    fill_reg    <= '0;
                end else begin
                    fill_reg    <= fill_reg + AW'(1);
                    last_cr_reg <= (s_rx_byte == CH_CR);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_byte && stat.start_data) begin
            len_reg    <= line_len;
            rd_idx_reg <= AW'(1);
        end else if (cmd.take_byte && stat.start_empty) begin
            out_byte_reg  <= 8'h00;
            out_empty_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end else if (cmd.load_first) begin
            out_byte_reg  <= rd_data_reg;
            out_empty_reg <= 1'b0;
            out_last_reg  <= (len_reg == rd_idx_reg);
        end else if (cmd.advance) begin
            out_byte_reg  <= rd_data_reg;
            out_empty_reg <= 1'b0;
            out_last_reg  <= (len_reg == rd_idx_inc);
            rd_idx_reg    <= rd_idx_inc;
        end
    end

    assign m_line_byte    = out_byte_reg;
    assign m_empty_line   = out_empty_reg;
    assign m_last_of_line = out_last_reg;

endmodule

// File: hw/rtl/uart_rx_line_assembler.sv
// Top level of the serial line assembler: controller plus datapath.
//
//   channel | ports                                           | direction
//   s_      | s_valid s_ready s_rx_byte                       | received byte in
//   m_      | m_valid m_ready m_line_byte m_empty_line        | line beat out
//           | m_last_of_line                                  |
//
// A data byte, or a newline that emits nothing, is taken while in ST_IDLE.
// A newline ending an n-byte line is taken in ST_IDLE, ST_LOAD moves the first
// stored byte out, then ST_SEND gives one beat per cycle while m_ready is high;
// an empty line goes straight to ST_SEND. Input is held off while a line is being sent.
// Synchronous active-low reset clears fill count, discard flag, trailing-CR flag and FSM.
// m_ready low simply holds the current beat; the store read is re-issued.
module uart_rx_line_assembler
    import ula_pkg::*;
#(
    parameter int LINE_BUF_BYTES = LINE_BUF_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_line_byte,
    output logic       m_empty_line,
    output logic       m_last_of_line
);

    ula_cmd_t  cmd;
    ula_stat_t stat;

    ula_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ula_dp #(
        .LINE_BUF_BYTES (LINE_BUF_BYTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_rx_byte      (s_rx_byte),
        .cmd            (cmd),
        .stat           (stat),
        .m_line_byte    (m_line_byte),
        .m_empty_line   (m_empty_line),
        .m_last_of_line (m_last_of_line)
    );

endmodule
